### hw/rtl/mccwd_pkg.sv
// shared constants, command codes and the command record of the checkin watchdog
package mccwd_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_BITS      = 3;
    localparam int TICK_BITS    = 32;
    localparam int MASK_BITS    = 8;
    localparam int OP_BITS      = 2;
    localparam int S_TDATA_BITS = 80;
    localparam int M_TDATA_BITS = 8;
    localparam int FIFO_DEPTH   = 2;
    localparam int PTR_BITS     = $clog2(FIFO_DEPTH);

    localparam logic [OP_BITS-1:0] OP_CHECKIN  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REGISTER = 2'd1;
    localparam logic [OP_BITS-1:0] OP_RUN      = 2'd2;

    localparam logic [1:0] KIND_NOP      = 2'd0;
    localparam logic [1:0] KIND_CHECKIN  = 2'd1;
    localparam logic [1:0] KIND_REGISTER = 2'd2;
    localparam logic [1:0] KIND_RUN      = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [CH_BITS-1:0]   channel;
        logic [TICK_BITS-1:0] interval;
        logic                 uses_cb;
        logic [TICK_BITS-1:0] now;
        logic [MASK_BITS-1:0] ok_mask;
    } cmd_t;

endpackage

### hw/rtl/multi_channel_checkin_watchdog.sv
// top level of the multi-channel checkin watchdog
//
//   channel   dir  tdata fields (lsb first)                               tuser
//   s_axis    in   channel 3, interval 32, uses_cb 1, now 32, ok_mask 8  opcode 2
//   m_axis    out  fault 1, fault_channel 3                              -
//
// check-in, register and unused opcodes are handled by the back end straight from its idle state
// a run is handled by the scan that reads one channel entry per cycle
// a two-entry command queue lets the input accept while the back end scans or the result waits
// a new command starts only when the result register is empty or being taken
// synchronous active-low reset clears the registered flags, the queue and the result valid
module multi_channel_checkin_watchdog
    import mccwd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // channel, interval_ticks, uses_callback, now_ticks, callback_ok_mask, zero pad
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // opcode
    input  logic [OP_BITS-1:0]      s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // fault, fault_channel, zero pad
    output logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    mccwd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    mccwd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    mccwd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hw/rtl/mccwd_front.sv
// input side: unpacks a transaction and classifies it into a command
module mccwd_front
    import mccwd_pkg::*;
(
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    input  logic [OP_BITS-1:0]      s_axis_tuser,
    output logic                    push_valid,
    input  logic                    push_ready,
    output cmd_t                    push_cmd
);

    logic [CH_BITS-1:0] channel;
    logic               ch_in_range;

    assign channel     = s_axis_tdata[2:0];
    assign ch_in_range = {1'b0, channel} < (CH_BITS+1)'(NUM_CHANNELS);

    always_comb begin
        push_cmd.channel  = channel;
        push_cmd.interval = s_axis_tdata[34:3];
        push_cmd.uses_cb  = s_axis_tdata[35];
        push_cmd.now      = s_axis_tdata[67:36];
        push_cmd.ok_mask  = s_axis_tdata[75:68];
        unique case (s_axis_tuser)
            OP_CHECKIN:  push_cmd.kind = ch_in_range ? KIND_CHECKIN : KIND_NOP;
            OP_REGISTER: push_cmd.kind = ch_in_range ? KIND_REGISTER : KIND_NOP;
            OP_RUN:      push_cmd.kind = KIND_RUN;
            default:     push_cmd.kind = KIND_NOP;
        endcase
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

### hw/rtl/mccwd_queue.sv
// short command queue between the front and the back
module mccwd_queue
    import mccwd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t                entries_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != (PTR_BITS+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_BITS+1)'(FIFO_DEPTH))
        else $error("queue count above depth");
`endif

endmodule

### hw/rtl/mccwd_back.sv
// back end: channel table, one-channel-per-cycle run scan and result register
module mccwd_back
    import mccwd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  cmd_t                    pop_cmd,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg, state_next;
    logic [CH_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic [TICK_BITS-1:0] run_now_reg;
    logic [MASK_BITS-1:0] run_mask_reg;
    logic                 found_reg, found_next;
    logic [CH_BITS-1:0]   found_ch_reg, found_ch_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_fault_reg, out_fault_next;
    logic [CH_BITS-1:0]   out_ch_reg, out_ch_next;

    logic [TICK_BITS-1:0] last_reg     [NUM_CHANNELS];
    logic [TICK_BITS-1:0] interval_reg [NUM_CHANNELS];
    logic                 cb_reg       [NUM_CHANNELS];
    logic                 registered_reg [NUM_CHANNELS];

    logic                 out_free, take, scan_last;
    logic                 refresh, check, overdue;
    logic [TICK_BITS-1:0] diff;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pop_ready = (state_reg == ST_IDLE) && out_free;
    assign take      = pop_valid && pop_ready;
    assign scan_last = scan_idx_reg == CH_BITS'(NUM_CHANNELS - 1);

    assign diff    = run_now_reg - last_reg[scan_idx_reg] - interval_reg[scan_idx_reg];
    assign overdue = (diff != '0) && !diff[TICK_BITS-1];
    assign refresh = (state_reg == ST_SCAN) && registered_reg[scan_idx_reg]
                     && cb_reg[scan_idx_reg] && run_mask_reg[scan_idx_reg];
    assign check   = (state_reg == ST_SCAN) && registered_reg[scan_idx_reg]
                     && !(cb_reg[scan_idx_reg] && run_mask_reg[scan_idx_reg]);

    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        found_ch_next  = found_ch_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_fault_next = out_fault_reg;
        out_ch_next    = out_ch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (pop_cmd.kind == KIND_RUN) begin
                        state_next    = ST_SCAN;
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        found_ch_next = '0;
                    end else begin
                        out_valid_next = 1'b1;
                        out_fault_next = 1'b0;
                        out_ch_next    = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (check && overdue && !found_reg) begin
                    found_next    = 1'b1;
                    found_ch_next = scan_idx_reg;
                end
                if (scan_last) begin
                    state_next     = ST_IDLE;
                    scan_idx_next  = '0;
                    out_valid_next = 1'b1;
                    out_fault_next = found_next;
                    out_ch_next    = found_ch_next;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg     <= found_next;
        found_ch_reg  <= found_ch_next;
        out_fault_reg <= out_fault_next;
        out_ch_reg    <= out_ch_next;
        if (take && pop_cmd.kind == KIND_RUN) begin
            run_now_reg  <= pop_cmd.now;
            run_mask_reg <= pop_cmd.ok_mask;
        end
    end

    // channel table, only the registered flags need a reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                registered_reg[i] <= 1'b0;
            end
        end else if (take && pop_cmd.kind == KIND_REGISTER) begin
            registered_reg[pop_cmd.channel] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && pop_cmd.kind == KIND_CHECKIN) begin
            last_reg[pop_cmd.channel] <= pop_cmd.now;
        end else if (take && pop_cmd.kind == KIND_REGISTER) begin
            last_reg[pop_cmd.channel]     <= '0;
            interval_reg[pop_cmd.channel] <= pop_cmd.interval;
            cb_reg[pop_cmd.channel]       <= pop_cmd.uses_cb;
        end else if (refresh) begin
            last_reg[scan_idx_reg] <= run_now_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_BITS-CH_BITS-1){1'b0}}, out_ch_reg, out_fault_reg};

`ifndef SYNTHESIS
    a_scan_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !out_valid_reg)
        else $error("result pending during scan");
    a_idle_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (scan_idx_reg == '0))
        else $error("scan index not parked");
    a_no_fault_ch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_fault_reg) |-> (out_ch_reg == '0))
        else $error("channel reported without fault");
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_last) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("scan end did not produce a result");
`endif

endmodule
